@@ hdl/sue_pkg.sv @@
// Package for the string unescape block: phase codes, result kinds, error codes,
// the decoder state type and the type of one run of results.
// Used by sue_step and string_unescape_to_utf8; depends on nothing.
`default_nettype none

package sue_pkg;

    localparam int RunMax = 4;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TEXT    = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX_HI  = 3'd3;
    localparam logic [2:0] PH_WANT_BS = 3'd4;
    localparam logic [2:0] PH_WANT_U  = 3'd5;
    localparam logic [2:0] PH_HEX_LO  = 3'd6;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_CONTROL   = 4'd1;
    localparam logic [3:0] ERR_INTERP    = 4'd2;
    localparam logic [3:0] ERR_ESC_CUT   = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
    localparam logic [3:0] ERR_NO_LOW    = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd8;
    localparam logic [3:0] ERR_NUL       = 4'd9;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  hex_count;
        logic [15:0] code_accum;
        logic [9:0]  high_bits;
        logic        hash_pending;
    } state_t;

    typedef struct packed {
        logic [2:0]                count;
        logic [RunMax-1:0][7:0]    bytes;
        logic [RunMax-1:0][1:0]    kinds;
        logic [RunMax-1:0][3:0]    errs;
    } run_t;

endpackage

`default_nettype wire

@@ hdl/sue_step.sv @@
// Combinational decoder for one input word: next state and up to four results.
// Depends on sue_pkg.
`default_nettype none

module sue_step
    import sue_pkg::*;
(
    input  var state_t     cur_state,
    input  wire  [7:0]     in_byte,
    input  wire            start_of_string,
    output var state_t     next_state,
    output var run_t       run
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic run_t utf8_run(input logic [20:0] cp);
        run_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    state_t      st;
    logic [4:0]  hv;
    logic [15:0] quad;
    logic        quad_done;

    assign hv        = hex_value(in_byte);
    assign quad      = {st.code_accum[11:0], hv[3:0]};
    assign quad_done = (st.hex_count == 2'd3);

    always_comb
    begin
        st = cur_state;
        if (start_of_string) begin
            st = '0;
            st.phase = PH_TEXT;
        end
        next_state = st;
        run = '0;

        unique case (st.phase) inside
            PH_TEXT:
            begin
                if (st.hash_pending && in_byte == CH_LBRACE) begin
                    run.kinds[0] = KIND_ERR;
                    run.errs[0]  = ERR_INTERP;
                    run.count    = 3'd1;
                    next_state.phase        = PH_IDLE;
                    next_state.hash_pending = 1'b0;
                end else begin
                    next_state.hash_pending = 1'b0;
                    if (st.hash_pending) begin
                        run.bytes[0] = CH_HASH;
                        run.count    = 3'd1;
                    end
                    if (in_byte < CH_SPACE) begin
                        run.kinds[run.count[1:0]] = KIND_ERR;
                        run.errs[run.count[1:0]]  = ERR_CONTROL;
                        run.count = run.count + 3'd1;
                        next_state.phase = PH_IDLE;
                    end else if (in_byte == CH_QUOTE) begin
                        run.kinds[run.count[1:0]] = KIND_END;
                        run.count = run.count + 3'd1;
                        next_state.phase = PH_IDLE;
                    end else if (in_byte == CH_HASH) begin
                        next_state.hash_pending = 1'b1;
                    end else if (in_byte == CH_BSLASH) begin
                        next_state.phase = PH_ESC;
                    end else begin
                        run.bytes[run.count[1:0]] = in_byte;
                        run.count = run.count + 3'd1;
                    end
                end
            end
            PH_ESC:
            begin
                next_state.phase = PH_TEXT;
                run.count = 3'd1;
                unique case (in_byte) inside
                    8'h00:
                    begin
                        run.kinds[0] = KIND_ERR;
                        run.errs[0]  = ERR_ESC_CUT;
                        next_state.phase = PH_IDLE;
                        next_state.hash_pending = 1'b0;
                    end
                    CH_QUOTE, CH_BSLASH, CH_SLASH: run.bytes[0] = in_byte;
                    CH_N: run.bytes[0] = 8'h0a;
                    CH_R: run.bytes[0] = 8'h0d;
                    CH_T: run.bytes[0] = 8'h09;
                    CH_B: run.bytes[0] = 8'h08;
                    CH_F: run.bytes[0] = 8'h0c;
                    CH_U:
                    begin
                        run.count = 3'd0;
                        next_state.phase      = PH_HEX_HI;
                        next_state.hex_count  = 2'd0;
                        next_state.code_accum = 16'h0000;
                    end
                    default:
                    begin
                        run.kinds[0] = KIND_ERR;
                        run.errs[0]  = ERR_BAD_ESC;
                        next_state.phase = PH_IDLE;
                        next_state.hash_pending = 1'b0;
                    end
                endcase
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (hv[4]) begin
                    run.kinds[0] = KIND_ERR;
                    run.errs[0]  = ERR_BAD_HEX;
                    run.count    = 3'd1;
                    next_state.phase = PH_IDLE;
                    next_state.hash_pending = 1'b0;
                end else begin
                    next_state.code_accum = quad;
                    next_state.hex_count  = st.hex_count + 2'd1;
                    if (quad_done && st.phase == PH_HEX_HI) begin
                        if (quad >= 16'hd800 && quad <= 16'hdbff) begin
                            next_state.high_bits = quad[9:0];
                            next_state.phase     = PH_WANT_BS;
                        end else if (quad >= 16'hdc00 && quad <= 16'hdfff) begin
                            run.kinds[0] = KIND_ERR;
                            run.errs[0]  = ERR_LONE_LOW;
                            run.count    = 3'd1;
                            next_state.phase = PH_IDLE;
                            next_state.hash_pending = 1'b0;
                        end else if (quad == 16'h0000) begin
                            run.kinds[0] = KIND_ERR;
                            run.errs[0]  = ERR_NUL;
                            run.count    = 3'd1;
                            next_state.phase = PH_IDLE;
                            next_state.hash_pending = 1'b0;
                        end else begin
                            run = utf8_run({5'd0, quad});
                            next_state.phase = PH_TEXT;
                        end
                    end else if (quad_done) begin
                        if (quad < 16'hdc00 || quad > 16'hdfff) begin
                            run.kinds[0] = KIND_ERR;
                            run.errs[0]  = ERR_BAD_LOW;
                            run.count    = 3'd1;
                            next_state.phase = PH_IDLE;
                            next_state.hash_pending = 1'b0;
                        end else begin
                            run = utf8_run(21'h10000
                                           + {1'b0, st.high_bits, quad[9:0]});
                            next_state.phase = PH_TEXT;
                        end
                    end
                end
            end
            PH_WANT_BS, PH_WANT_U:
            begin
                if ((st.phase == PH_WANT_BS && in_byte != CH_BSLASH)
                    || (st.phase == PH_WANT_U && in_byte != CH_U)) begin
                    run.kinds[0] = KIND_ERR;
                    run.errs[0]  = ERR_NO_LOW;
                    run.count    = 3'd1;
                    next_state.phase = PH_IDLE;
                    next_state.hash_pending = 1'b0;
                end else if (st.phase == PH_WANT_BS) begin
                    next_state.phase = PH_WANT_U;
                end else begin
                    next_state.phase      = PH_HEX_LO;
                    next_state.hex_count  = 2'd0;
                    next_state.code_accum = 16'h0000;
                end
            end
            default:
            begin
                next_state.phase = PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/string_unescape_to_utf8.sv @@
// Top level of the string unescape block: decoder state, result run buffer, handshakes.
// Depends on sue_pkg and sue_step.
`default_nettype none

// Decodes a quoted string body, one input word per cycle, into UTF-8 data words,
// an end word at the closing quote or an error word. Each input word is decoded in
// the cycle it is accepted and its run of zero to four results is loaded into a
// four-entry output buffer, drained one result per cycle from the front while
// out_ready is high. A new word is taken whenever the buffer is empty or its last
// result is being taken, so plain text flows at one word per cycle while out_ready
// is high, and a word that yields several results, such as a multi-byte character
// or a held hash released ahead of the next byte, holds the input until they drain.
module string_unescape_to_utf8
    import sue_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] in_byte,
    input  wire        start_of_string,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] result_kind,
    output logic [3:0] error_code,
    output logic       last_of_run
);

    state_t                 state_reg;
    state_t                 state_next;
    run_t                   run;
    logic [2:0]             left_reg;
    logic [2:0]             left_next;
    logic [RunMax-1:0][7:0] bytes_reg;
    logic [RunMax-1:0][1:0] kinds_reg;
    logic [RunMax-1:0][3:0] errs_reg;
    logic                   in_take;
    logic                   out_take;

    sue_step u_step (
        .cur_state       (state_reg),
        .in_byte         (in_byte),
        .start_of_string (start_of_string),
        .next_state      (state_next),
        .run             (run)
    );

    assign out_valid   = (left_reg != 3'd0);
    assign out_take    = out_valid && out_ready;
    assign in_ready    = (left_reg == 3'd0) || (left_reg == 3'd1 && out_ready);
    assign in_take     = in_valid && in_ready;
    assign out_byte    = bytes_reg[0];
    assign result_kind = kinds_reg[0];
    assign error_code  = errs_reg[0];
    assign last_of_run = (left_reg == 3'd1);

    always_comb
    begin
        left_next = left_reg;
        if (in_take)
            left_next = run.count;
        else if (out_take)
            left_next = left_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
            left_reg  <= 3'd0;
        end else begin
            left_reg <= left_next;
            if (in_take)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            bytes_reg <= run.bytes;
            kinds_reg <= run.kinds;
            errs_reg  <= run.errs;
        end else if (out_take) begin
            bytes_reg <= {8'h00, bytes_reg[RunMax-1:1]};
            kinds_reg <= {KIND_DATA, kinds_reg[RunMax-1:1]};
            errs_reg  <= {ERR_NONE, errs_reg[RunMax-1:1]};
        end
    end

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd4)
        else $error("result buffer count out of range");

    a_no_early_take: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg > 3'd1) |-> !in_ready)
        else $error("input taken while earlier results remain");

    a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != KIND_ERR) |-> (error_code == ERR_NONE))
        else $error("error code on a non-error result");

    a_idle_no_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> !state_reg.hash_pending)
        else $error("held hash while idle");
`endif

endmodule

`default_nettype wire
